>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clock edge outside reset
`define ASSERT_CLK(label, clk_sig, rstn_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// check antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> src/pxp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxp_pkg
// Request and response types and mode codes of the paired XOR parity generator.
// ----------------------------------------------------------------------------
package pxp_pkg;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic [8:0] packet_len;
    } pxp_req_t;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       parity_valid;
        logic [7:0] byte_index;
        logic       packet_done;
        logic       parity_ready;
        logic [8:0] parity_len;
    } pxp_rsp_t;

endpackage

>>> src/pxp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxp_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module pxp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/paired_xor_parity_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_xor_parity_generator_core
// Pairs each packet with the previous one of equal length and emits the
// bytewise XOR parity, one response per request.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake             | Payload
// req     | in  | req_valid / req_ready | pxp_req_t (mode, data_byte, packet_len)
// rsp     | out | rsp_valid / rsp_ready | pxp_rsp_t (parity, index, flags, len)
//
// One request per cycle while rsp is not stalled; an accepted request passes the
// registered read of the packet RAM and then the output register.
// Reset clears control state only; packet RAM contents are not cleared.
// A stalled rsp holds both stages; req_ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module paired_xor_parity_generator_core
    import pxp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  pxp_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pxp_rsp_t rsp
);

    localparam int POS_W = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       pvalid;
        logic [7:0] index;
        logic       done;
        logic       pready;
        logic [8:0] plen;
    } pxp_stage_t;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [8:0]       stored_len_reg, stored_len_next;
    logic             have_prev_reg, have_prev_next;
    logic             ready_reg, ready_next;
    logic             match_reg, match_next;

    logic             s1_valid_reg;
    pxp_stage_t       s1_reg, s1_next;
    logic             rsp_valid_reg;
    pxp_rsp_t         rsp_reg;

    logic             accept;
    logic             s1_advance;
    logic             first_byte;
    logic             ignored;
    logic             done;
    logic             wr_en;
    logic [8:0]       eff_len;
    logic [POS_W+7:0] pos_ext;
    logic [7:0]       rd_data;

    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign accept     = req_valid && req_ready;

    assign first_byte = (pos_reg == '0);
    assign ignored    = first_byte && ((req.packet_len == 9'd0) ||
                        (32'(req.packet_len) > 32'(MAX_PACKET_BYTES)));
    assign eff_len    = first_byte ? req.packet_len : stored_len_reg;
    assign done       = (32'(pos_reg) + 32'd1) >= 32'(eff_len);
    assign pos_ext    = {8'd0, pos_reg};
    assign wr_en      = accept && (req.mode == MODE_BYTE) && !ignored;

    always_comb
    begin
        pos_next        = pos_reg;
        stored_len_next = stored_len_reg;
        have_prev_next  = have_prev_reg;
        ready_next      = ready_reg;
        match_next      = match_reg;
        s1_next         = '0;
        s1_next.pready  = ready_reg;
        s1_next.plen    = ready_reg ? stored_len_reg : 9'd0;
        if (req.mode == MODE_CLEAR)
        begin
            pos_next        = '0;
            stored_len_next = 9'd0;
            have_prev_next  = 1'b0;
            ready_next      = 1'b0;
            match_next      = 1'b0;
            s1_next         = '0;
        end
        else if (!ignored)
        begin
            if (first_byte)
            begin
                match_next      = have_prev_reg && (req.packet_len == stored_len_reg);
                stored_len_next = req.packet_len;
                have_prev_next  = 1'b1;
                if (!match_next)
                begin
                    ready_next = 1'b0;
                end
            end
            if (done)
            begin
                pos_next = '0;
                if (match_next)
                begin
                    ready_next = 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            s1_next.data_byte = req.data_byte;
            s1_next.pvalid    = match_next;
            s1_next.index     = pos_ext[7:0];
            s1_next.done      = done;
            s1_next.pready    = ready_next;
            s1_next.plen      = ready_next ? stored_len_next : 9'd0;
        end
    end

    pxp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PACKET_BYTES)
    ) u_packet_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (req.data_byte),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            stored_len_reg <= 9'd0;
            have_prev_reg  <= 1'b0;
            ready_reg      <= 1'b0;
            match_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg        <= pos_next;
                stored_len_reg <= stored_len_next;
                have_prev_reg  <= have_prev_next;
                ready_reg      <= ready_next;
                match_reg      <= match_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_advance)
        begin
            rsp_reg.parity_byte  <= s1_reg.pvalid ? (rd_data ^ s1_reg.data_byte) : 8'd0;
            rsp_reg.parity_valid <= s1_reg.pvalid;
            rsp_reg.byte_index   <= s1_reg.index;
            rsp_reg.packet_done  <= s1_reg.done;
            rsp_reg.parity_ready <= s1_reg.pready;
            rsp_reg.parity_len   <= s1_reg.plen;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_IMPL(a_pos_in_packet, clk, rst_n, pos_reg != '0,
        32'(pos_reg) < 32'(stored_len_reg), "byte position beyond stored length")
    `ASSERT_IMPL(a_pos_needs_prev, clk, rst_n, pos_reg != '0, have_prev_reg,
        "mid-packet position without a stored packet")
    `ASSERT_IMPL(a_ready_needs_prev, clk, rst_n, ready_reg, have_prev_reg,
        "parity ready without a stored packet")
    `ASSERT_IMPL(a_full_stall, clk, rst_n, s1_valid_reg && rsp_valid_reg && !rsp_ready,
        !req_ready, "request taken while both stages are stalled")

endmodule
